// ===== rtl/core/asc_pkg.sv =====
`timescale 1ns / 1ps

package asc_pkg;

	// Sponge geometry.
	localparam int RATE_BYTES  = 8;
	localparam int PERM_ROUNDS = 12;
	localparam int LANE_W      = 64;
	localparam int POS_W       = 4;
	localparam int ROUND_W     = 4;

	// Input word kinds as they arrive on the stream.
	localparam logic [1:0] KIND_START   = 2'd0;
	localparam logic [1:0] KIND_ABSORB  = 2'd1;
	localparam logic [1:0] KIND_SQUEEZE = 2'd2;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;

	// Configuration register indexes.
	localparam logic [0:0] REG_HASH_IV = 1'b0;
	localparam logic [0:0] REG_XOF_IV  = 1'b1;

	// Reset values of the initial values.
	localparam logic [LANE_W-1:0] HASH_IV_RESET = 64'd8800401358850;
	localparam logic [LANE_W-1:0] XOF_IV_RESET  = 64'd8796106391555;

	// Padding byte for the first squeeze.
	localparam logic [7:0] PAD_BYTE = 8'h01;

	// Round constants of the permutation, first round first.
	localparam logic [7:0] ROUND_CONST [PERM_ROUNDS] = '{
		8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5,
		8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
	};

	typedef logic [4:0][LANE_W-1:0] lanes_t;

	typedef enum logic [1:0] {
		OP_START,
		OP_ABSORB,
		OP_SQUEEZE
	} op_t;

	// Classified command handed from the front queue to the engine.
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       xof;
	} cmd_t;

	function automatic logic [LANE_W-1:0] rotr(input logic [LANE_W-1:0] v, input int unsigned n);
		return (v >> n) | (v << (LANE_W - n));
	endfunction

	// One round: constant addition, substitution layer and linear diffusion.
	function automatic lanes_t asc_round(input lanes_t s, input logic [7:0] rc);
		logic [LANE_W-1:0] x0, x1, x2, x3, x4;
		logic [LANE_W-1:0] t0, t1, t2, t3, t4;
		lanes_t r;
		x0 = s[0];
		x1 = s[1];
		x2 = s[2] ^ {{(LANE_W-8){1'b0}}, rc};
		x3 = s[3];
		x4 = s[4];
		x0 = x0 ^ x4;
		x4 = x4 ^ x3;
		x2 = x2 ^ x1;
		t0 = ~x0 & x1;
		t1 = ~x1 & x2;
		t2 = ~x2 & x3;
		t3 = ~x3 & x4;
		t4 = ~x4 & x0;
		x0 = x0 ^ t1;
		x1 = x1 ^ t2;
		x2 = x2 ^ t3;
		x3 = x3 ^ t4;
		x4 = x4 ^ t0;
		x1 = x1 ^ x0;
		x0 = x0 ^ x4;
		x3 = x3 ^ x2;
		x2 = ~x2;
		r[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
		r[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
		r[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
		r[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
		r[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
		return r;
	endfunction

endpackage

// ===== rtl/core/asc_front.sv =====
`timescale 1ns / 1ps

module asc_front #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     in_kind,
	input  logic [7:0]     in_data,
	input  logic           in_xof,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output asc_pkg::cmd_t  cmd
);
	import asc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	cmd_t             cls;
	logic             known;
	logic             push;
	logic             pop;

	// Classify the incoming word; the unused kind is taken and dropped.
	always_comb begin
		cls.data = in_data;
		cls.xof  = in_xof;
		cls.op   = OP_START;
		known    = 1'b1;
		unique case (in_kind)
			KIND_START:   cls.op = OP_START;
			KIND_ABSORB:  cls.op = OP_ABSORB;
			KIND_SQUEEZE: cls.op = OP_SQUEEZE;
			default:      known = 1'b0;
		endcase
	end

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign push      = in_valid && in_ready && known;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   count_q <= CNT_W'(count_q + 1'b1);
				2'b01:   count_q <= CNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/asc_back.sv =====
`timescale 1ns / 1ps

module asc_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  asc_pkg::cmd_t            cmd,
	input  logic [asc_pkg::LANE_W-1:0] hash_iv,
	input  logic [asc_pkg::LANE_W-1:0] xof_iv,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [7:0]               out_byte
);
	import asc_pkg::*;

	localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(PERM_ROUNDS - 1);
	localparam logic [POS_W-1:0]   RATE_POS   = POS_W'(RATE_BYTES);
	localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(RATE_BYTES - 1);

	lanes_t             lanes_q, lanes_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic               pad_q, pad_d;
	logic               busy_q, busy_d;
	logic               emit_q, emit_d;
	logic [ROUND_W-1:0] round_q, round_d;
	logic               out_valid_q, out_valid_d;
	logic [7:0]         out_byte_q, out_byte_d;
	lanes_t             round_out;
	logic               in_rate;
	logic [5:0]         shift;
	logic               take;

	assign in_rate   = (pos_q < RATE_POS);
	assign shift     = {pos_q[2:0], 3'b000};
	assign round_out = asc_round(lanes_q, ROUND_CONST[round_q]);

	// A squeeze needs the output slot free or draining; nothing enters mid-permutation.
	assign cmd_ready = !busy_q && ((cmd.op != OP_SQUEEZE) || !out_valid_q || out_ready);
	assign take      = cmd_valid && cmd_ready;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

	// Next state of the sponge and the output slot.
	always_comb begin
		lanes_d     = lanes_q;
		pos_d       = pos_q;
		pad_d       = pad_q;
		busy_d      = busy_q;
		emit_d      = emit_q;
		round_d     = round_q;
		out_valid_d = out_valid_q && !out_ready;
		out_byte_d  = out_byte_q;
		if (busy_q) begin
			lanes_d = round_out;
			if (round_q == LAST_ROUND) begin
				busy_d  = 1'b0;
				round_d = '0;
				if (emit_q) begin
					out_valid_d = 1'b1;
					out_byte_d  = round_out[0][7:0];
					pos_d       = POS_W'(1);
					emit_d      = 1'b0;
				end
			end else begin
				round_d = ROUND_W'(round_q + 1'b1);
			end
		end else if (take) begin
			unique case (cmd.op)
				OP_START: begin
					lanes_d    = '0;
					lanes_d[0] = cmd.xof ? xof_iv : hash_iv;
					pos_d      = '0;
					pad_d      = 1'b1;
					busy_d     = 1'b1;
				end
				OP_ABSORB: begin
					if (in_rate) begin
						lanes_d[0] = lanes_q[0] ^ (LANE_W'(cmd.data) << shift);
					end
					if (pos_q >= LAST_POS) begin
						pos_d  = '0;
						busy_d = 1'b1;
					end else begin
						pos_d = POS_W'(pos_q + 1'b1);
					end
				end
				OP_SQUEEZE: begin
					if (pad_q) begin
						if (in_rate) begin
							lanes_d[0] = lanes_q[0] ^ (LANE_W'(PAD_BYTE) << shift);
						end
						pad_d  = 1'b0;
						pos_d  = '0;
						busy_d = 1'b1;
						emit_d = 1'b1;
					end else if (!in_rate) begin
						pos_d  = '0;
						busy_d = 1'b1;
						emit_d = 1'b1;
					end else begin
						out_valid_d = 1'b1;
						out_byte_d  = lanes_q[0][shift +: 8];
						pos_d       = POS_W'(pos_q + 1'b1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Sponge state and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q     <= '0;
			pos_q       <= '0;
			pad_q       <= 1'b0;
			busy_q      <= 1'b0;
			emit_q      <= 1'b0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			lanes_q     <= lanes_d;
			pos_q       <= pos_d;
			pad_q       <= pad_d;
			busy_q      <= busy_d;
			emit_q      <= emit_d;
			round_q     <= round_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Output byte register.
	always_ff @(posedge clk) begin
		out_byte_q <= out_byte_d;
	end

endmodule

// ===== rtl/core/ascon_sponge_hash_xof_unit.sv =====
`timescale 1ns / 1ps
// A squeeze word that needs no permutation shows its byte through the queue register and
// the output register; one that permutes first runs the 12 rounds in between.
// One word per cycle unless permuting or output-stalled; a start, a rate-filling absorb,
// the first or a rate-crossing squeeze holds the engine 12 rounds, one round per cycle.
// Reset (arst_n low, asynchronous) clears the state, the queue and the output, and restores
// both initial-value registers.

module ascon_sponge_hash_xof_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic [2:0]  s_axis_tuser,   // [1:0] kind, [2] xof_mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import asc_pkg::*;

	logic [LANE_W-1:0] hash_iv_q;
	logic [LANE_W-1:0] xof_iv_q;
	logic              cmd_valid;
	logic              cmd_ready;
	cmd_t              cmd;

	assign cfg_ready = 1'b1;

	// Initial-value registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_iv_q <= HASH_IV_RESET;
			xof_iv_q  <= XOF_IV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HASH_IV: hash_iv_q <= cfg_data;
				REG_XOF_IV:  xof_iv_q  <= cfg_data;
			endcase
		end
	end

	// Front queue: takes words and classifies them.
	asc_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser[1:0]),
		.in_data  (s_axis_tdata),
		.in_xof   (s_axis_tuser[2]),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	// Sponge engine with the output register.
	asc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.hash_iv  (hash_iv_q),
		.xof_iv   (xof_iv_q),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_byte (m_axis_tdata)
	);

endmodule

// ===== rtl/core/asc_checker.sv =====
`timescale 1ns / 1ps

module asc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	// A stalled output word stays and keeps its byte.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word dropped or changed while stalled");

	// The queue only fills up through an accepted word.
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("input ready fell without an accepted word");

	// Leaving reset, the queue is empty and no result is pending.
	a_reset_clean: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> s_axis_tready && !m_axis_tvalid)
		else $error("unit not clean after reset");

endmodule

bind ascon_sponge_hash_xof_unit asc_checker u_asc_checker (.*);

// ===== tb/sv/ascon_sponge_hash_xof_unit_tb.sv =====
`timescale 1ns / 1ps

module ascon_sponge_hash_xof_unit_tb;

	import asc_pkg::*;

	// Tracks the sponge state word by word and holds the output bytes still due.
	class sponge_tracker;
		logic [63:0] lane [5];
		logic [3:0]  pos;
		bit          pad_armed;
		logic [63:0] hash_iv;
		logic [63:0] xof_iv;
		logic [7:0]  due_bytes [$];
		int          errors;

		function new();
			for (int i = 0; i < 5; i++) begin
				lane[i] = '0;
			end
			pos       = '0;
			pad_armed = 1'b0;
			hash_iv   = HASH_IV_RESET;
			xof_iv    = XOF_IV_RESET;
			errors    = 0;
		endfunction

		function void write_reg(logic [0:0] idx, logic [63:0] value);
			if (idx == REG_HASH_IV) begin
				hash_iv = value;
			end else begin
				xof_iv = value;
			end
		endfunction

		function logic [63:0] ror(logic [63:0] v, int n);
			return (v >> n) | (v << (64 - n));
		endfunction

		// Twelve rounds of constant addition, S-box layer and lane diffusion.
		function void permute();
			logic [63:0] a0, a1, a2, a3, a4;
			logic [63:0] n0, n1, n2, n3, n4;
			a0 = lane[0];
			a1 = lane[1];
			a2 = lane[2];
			a3 = lane[3];
			a4 = lane[4];
			for (int r = 0; r < PERM_ROUNDS; r++) begin
				a2 = a2 ^ {56'd0, ROUND_CONST[r]};
				a0 = a0 ^ a4;
				a4 = a4 ^ a3;
				a2 = a2 ^ a1;
				n0 = ~a0 & a1;
				n1 = ~a1 & a2;
				n2 = ~a2 & a3;
				n3 = ~a3 & a4;
				n4 = ~a4 & a0;
				a0 = a0 ^ n1;
				a1 = a1 ^ n2;
				a2 = a2 ^ n3;
				a3 = a3 ^ n4;
				a4 = a4 ^ n0;
				a1 = a1 ^ a0;
				a0 = a0 ^ a4;
				a3 = a3 ^ a2;
				a2 = ~a2;
				a0 = a0 ^ ror(a0, 19) ^ ror(a0, 28);
				a1 = a1 ^ ror(a1, 61) ^ ror(a1, 39);
				a2 = a2 ^ ror(a2, 1) ^ ror(a2, 6);
				a3 = a3 ^ ror(a3, 10) ^ ror(a3, 17);
				a4 = a4 ^ ror(a4, 7) ^ ror(a4, 41);
			end
			lane[0] = a0;
			lane[1] = a1;
			lane[2] = a2;
			lane[3] = a3;
			lane[4] = a4;
		endfunction

		// A byte beyond the rate is dropped.
		function void mix_byte(logic [7:0] b);
			if (pos < RATE_BYTES) begin
				lane[0] = lane[0] ^ ({56'd0, b} << (8 * pos));
			end
		endfunction

		// Applies one accepted input word and queues the byte it yields, if any.
		function void take_word(logic [1:0] kind, logic [7:0] data, logic xof);
			case (kind)
				KIND_START: begin
					lane[0] = xof ? xof_iv : hash_iv;
					for (int i = 1; i < 5; i++) begin
						lane[i] = '0;
					end
					pos       = '0;
					pad_armed = 1'b1;
					permute();
				end
				KIND_ABSORB: begin
					mix_byte(data);
					pos = pos + 1'b1;
					if (pos >= RATE_BYTES) begin
						permute();
						pos = '0;
					end
				end
				KIND_SQUEEZE: begin
					if (pad_armed) begin
						mix_byte(PAD_BYTE);
						permute();
						pos       = '0;
						pad_armed = 1'b0;
					end
					if (pos >= RATE_BYTES) begin
						permute();
						pos = '0;
					end
					due_bytes.push_back(8'(lane[0] >> (8 * pos)));
					pos = pos + 1'b1;
				end
				default: begin
				end
			endcase
		endfunction

		function void check_byte(logic [7:0] got);
			logic [7:0] want;
			if (due_bytes.size() == 0) begin
				$error("out_byte expected none actual %02h", got);
				errors++;
			end else begin
				want = due_bytes.pop_front();
				if (got !== want) begin
					$error("out_byte expected %02h actual %02h", want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return due_bytes.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic [2:0]  s_axis_tuser;   // [1:0] kind, [2] xof_mode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // [7:0] out_byte
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [63:0] cfg_data;

	sponge_tracker sponge = new();

	int sent_items = 0;
	int hold_asks  = 0;
	int hold_done  = 0;
	bit steady     = 1'b0;

	ascon_sponge_hash_xof_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;

	always #5 clk = ~clk;

	// Mostly short gaps, a few long ones, none while a steady stretch runs.
	function automatic int pick_gap();
		int r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Offers one word and waits for its handshake; tready is sampled mid-cycle.
	task automatic send_word(input logic [1:0] kind, input logic [7:0] data, input logic xof);
		int gap;
		bit took;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= {xof, kind};
		do begin
			@(negedge clk);
			took = s_axis_tready;
			@(posedge clk);
		end while (!took);
		sponge.take_word(kind, data, xof);
		if (kind != KIND_UNUSED) begin
			sent_items++;
		end
	endtask

	// Writes both initial values; only called while the block is idle.
	task automatic set_init_values(input logic [63:0] hash_value, input logic [63:0] xof_value);
		bit took;
		for (int i = 0; i < 2; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (i == 0) ? REG_HASH_IV : REG_XOF_IV;
			cfg_data  <= (i == 0) ? hash_value : xof_value;
			do begin
				@(negedge clk);
				took = cfg_ready;
				@(posedge clk);
			end while (!took);
			sponge.write_reg((i == 0) ? REG_HASH_IV : REG_XOF_IV,
				(i == 0) ? hash_value : xof_value);
		end
		cfg_valid <= 1'b0;
	endtask

	// Waits for every due byte, then for any trailing permutation to finish.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sponge.pending() > 0) begin
			@(posedge clk);
		end
		repeat (64) @(posedge clk);
	endtask

	// A start, a message of random bytes and a run of squeezes.
	task automatic run_message();
		logic xof;
		int   n_abs;
		int   n_sq;
		xof    = 1'($urandom);
		steady = ($urandom_range(0, 3) == 0);
		n_abs  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 70) : $urandom_range(0, 24);
		if (!xof && $urandom_range(0, 1)) begin
			n_sq = 32;
		end else begin
			n_sq = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 16);
		end
		send_word(KIND_START, 8'($urandom), xof);
		for (int i = 0; i < n_abs; i++) begin
			if ($urandom_range(0, 39) == 0) begin
				send_word(KIND_UNUSED, 8'($urandom), 1'($urandom));
			end
			send_word(KIND_ABSORB, 8'($urandom), 1'($urandom));
		end
		for (int i = 0; i < n_sq; i++) begin
			send_word(KIND_SQUEEZE, 8'($urandom), 1'($urandom));
		end
	endtask

	// Words of any kind in any order, including absorbs after squeezing.
	task automatic run_noise();
		int n;
		n      = $urandom_range(1, 6);
		steady = 1'b0;
		for (int i = 0; i < n; i++) begin
			send_word(2'($urandom), 8'($urandom), 1'($urandom));
		end
	endtask

	task automatic run_phase(input int phase);
		int base;
		int r;
		base = sent_items;
		// The receiver holds off while squeezes keep coming, so the input backs up.
		if (phase == 2) begin
			steady = 1'b1;
			send_word(KIND_START, 8'h00, 1'b0);
			hold_asks++;
			for (int i = 0; i < 60; i++) begin
				send_word(KIND_SQUEEZE, 8'($urandom), 1'($urandom));
			end
		end
		while (sent_items - base < 270) begin
			r = $urandom_range(0, 99);
			if (r < 82) begin
				run_message();
			end else if (r < 95) begin
				run_noise();
			end else begin
				drain();
			end
		end
	endtask

	// Result side: random stalls in some stretches, always ready in others.
	initial begin
		int   mode_left;
		int   stall_left;
		bit   calm;
		bit   rdy;
		bit   hit;
		logic [7:0] seen;
		m_axis_tready = 1'b0;
		mode_left  = 0;
		stall_left = 0;
		calm       = 1'b0;
		hit        = 1'b0;
		seen       = '0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_done != hold_asks) begin
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_done++;
			end
			if (mode_left == 0) begin
				calm      = ($urandom_range(0, 2) == 0);
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			if (calm) begin
				rdy = 1'b1;
			end else if (stall_left > 0) begin
				rdy = 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 99) < 65) begin
				rdy = 1'b1;
			end else begin
				rdy        = 1'b0;
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
			end
			m_axis_tready <= rdy;
			@(negedge clk);
			hit  = m_axis_tvalid && m_axis_tready;
			seen = m_axis_tdata;
			@(posedge clk);
			if (hit) begin
				sponge.check_byte(seen);
			end
		end
	end

	// Main sequence: reset, directed words, then random phases over several IV settings.
	initial begin
		logic [63:0] hash_value;
		logic [63:0] xof_value;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_init_values(HASH_IV_RESET, XOF_IV_RESET);

		// Squeeze and absorb on the cleared state, then an ignored word.
		steady = 1'b0;
		send_word(KIND_SQUEEZE, 8'h00, 1'b0);
		send_word(KIND_ABSORB, 8'hff, 1'b1);
		send_word(KIND_UNUSED, 8'h5a, 1'b1);
		// A short hash with both byte extremes, squeezed to a full rate.
		send_word(KIND_START, 8'hff, 1'b0);
		send_word(KIND_ABSORB, 8'h00, 1'b0);
		send_word(KIND_ABSORB, 8'hff, 1'b1);
		for (int i = 0; i < 8; i++) begin
			send_word(KIND_SQUEEZE, 8'h00, 1'b0);
		end
		// Absorb at a full rate drops the byte and permutes.
		send_word(KIND_ABSORB, 8'h3c, 1'b0);
		send_word(KIND_SQUEEZE, 8'hff, 1'b1);
		// An XOF message that fills the rate exactly.
		send_word(KIND_START, 8'h00, 1'b1);
		for (int i = 0; i < 8; i++) begin
			send_word(KIND_ABSORB, 8'($urandom), 1'($urandom));
		end
		send_word(KIND_SQUEEZE, 8'h00, 1'b0);
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				1: begin
					hash_value = '0;
					xof_value  = '1;
				end
				2: begin
					hash_value = '1;
					xof_value  = '0;
				end
				3: begin
					hash_value = {$urandom, $urandom};
					xof_value  = {$urandom, $urandom};
				end
				default: begin
					hash_value = HASH_IV_RESET;
					xof_value  = XOF_IV_RESET;
				end
			endcase
			set_init_values(hash_value, xof_value);
			run_phase(phase);
			drain();
		end

		if (sponge.errors == 0 && sponge.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog for a hung handshake or missing bytes.
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
